>>> rtl/core/eehr_pkg.sv
// Shared types and constants of the edge event history ring.
package eehr_pkg;

    localparam int STAMP_W     = 64;
    localparam int CMD_W       = 2;
    localparam int LIMIT_W     = 16;
    localparam int CNT32_W     = 32;
    localparam int MAX_RESULTS = 64;
    localparam int RESULT_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_LOG   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REF   = 2'd2;

    typedef struct packed {
        logic [CNT32_W-1:0] rise;
        logic [CNT32_W-1:0] fall;
    } edge_cnt_t;

    typedef struct packed {
        logic               event_valid;
        logic               event_level;
        logic [STAMP_W-1:0] event_time_us;
        logic               last;
        logic [CNT32_W-1:0] dropped_total;
        logic [CNT32_W-1:0] rise_count;
        logic [CNT32_W-1:0] fall_count;
        logic [CNT32_W-1:0] change_count;
    } result_t;

endpackage

>>> rtl/core/eehr_if.sv
// Handshake channels for request words and result words.
interface eehr_req_if
    import eehr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic               level;
    logic [STAMP_W-1:0] sample_time;
    logic [LIMIT_W-1:0] event_limit;

    modport source (output valid, command, level, sample_time, event_limit, input ready);
    modport sink   (input valid, command, level, sample_time, event_limit, output ready);
endinterface

interface eehr_res_if
    import eehr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               event_valid;
    logic               event_level;
    logic [STAMP_W-1:0] event_time_us;
    logic               last;
    logic [CNT32_W-1:0] dropped_total;
    logic [CNT32_W-1:0] rise_count;
    logic [CNT32_W-1:0] fall_count;
    logic [CNT32_W-1:0] change_count;

    modport source (output valid, event_valid, event_level, event_time_us, last,
                    dropped_total, rise_count, fall_count, change_count, input ready);
    modport sink   (input valid, event_valid, event_level, event_time_us, last,
                    dropped_total, rise_count, fall_count, change_count, output ready);
endinterface

>>> rtl/core/edge_event_history_ring.sv
// Top level of the edge event history ring: log, drain and reference sequencer.
// Each request word gives one or more result words on the result channel, the
// last marked by last. Log, reference, unused and zero-limit drain requests
// give one result word each and can follow back to back while the sink keeps
// up; a drain that returns N events holds request.ready low until its last
// ring RAM read is issued, one read per event, each waiting for queue room.
// Each result word passes the pending result registers (for an event, the RAM
// read register) and then the result queue on its way to the result channel.
// Samples sit in one RAM of CAPACITY entries holding level and 64-bit stamp;
// it is not cleared after reset and needs no clearing pass. A two-word result
// queue lets requests keep coming while the sink stalls, until the queue fills.
module edge_event_history_ring
    import eehr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    eehr_req_if.sink   request,
    eehr_res_if.source result
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int SW     = (FILL_W > RESULT_W) ? FILL_W : RESULT_W;
    localparam int MEM_W  = STAMP_W + 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [AW-1:0]       wp_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [CNT32_W-1:0]  ovf_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [RESULT_W-1:0] remain_reg;
    logic [CNT32_W-1:0]  lost_reg;
    logic                p_reg;
    logic                p_event_reg;
    logic                p_last_reg;
    logic [CNT32_W-1:0]  p_dropped_reg;

    logic                accept;
    logic                is_log;
    logic                is_ref;
    logic                is_drain;
    logic                drain_go;
    logic                drain_any;
    logic                room;
    logic                issue;
    logic                pop;
    logic [1:0]          q_count;
    logic [RESULT_W-1:0] limit;
    logic [SW-1:0]       cnt_sel;
    logic [SW:0]         tail_wide;
    logic [CNT32_W-1:0]  lost_calc;
    logic [MEM_W-1:0]    rdata;
    edge_cnt_t           ecnt;
    result_t             push_data;

    assign pop    = result.valid && result.ready;
    assign room   = ({1'b0, q_count} + {2'b0, p_reg}) < (3'd2 + {2'b0, pop});
    assign request.ready = (state_reg == ST_IDLE) && room;
    assign accept   = request.valid && request.ready;
    assign is_log   = accept && (request.command == CMD_LOG);
    assign is_ref   = accept && (request.command == CMD_REF);
    assign is_drain = accept && (request.command == CMD_DRAIN);
    assign issue    = (state_reg == ST_DRAIN) && room;

    assign limit = (request.event_limit > LIMIT_W'(MAX_RESULTS))
                   ? RESULT_W'(MAX_RESULTS) : request.event_limit[RESULT_W-1:0];
    assign cnt_sel = (SW'(fill_reg) < SW'(limit)) ? SW'(fill_reg) : SW'(limit);
    assign tail_wide = ((SW+1)'(wp_reg) >= (SW+1)'(cnt_sel))
                       ? (SW+1)'(wp_reg) - (SW+1)'(cnt_sel)
                       : (SW+1)'(wp_reg) + (SW+1)'(CAPACITY) - (SW+1)'(cnt_sel);
    assign lost_calc = CNT32_W'(SW'(fill_reg) - cnt_sel) + ovf_reg;

    assign drain_any = is_drain && (limit != '0);
    assign drain_go  = drain_any && (cnt_sel != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (drain_go)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (issue && (remain_reg == RESULT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            ovf_reg   <= '0;
            p_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= (accept && !drain_go) || issue;
            if (is_log)
            begin
                wp_reg <= (wp_reg == AW'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg < FILL_W'(CAPACITY))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= ovf_reg + 1'b1;
                end
            end
            else if (drain_any)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
                ovf_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain_go)
        begin
            rd_ptr_reg <= AW'(tail_wide);
            remain_reg <= RESULT_W'(cnt_sel);
            lost_reg   <= lost_calc;
        end
        else if (issue)
        begin
            rd_ptr_reg <= (rd_ptr_reg == AW'(CAPACITY - 1)) ? '0 : rd_ptr_reg + 1'b1;
            remain_reg <= remain_reg - 1'b1;
        end

        if (issue)
        begin
            p_event_reg   <= 1'b1;
            p_last_reg    <= (remain_reg == RESULT_W'(1));
            p_dropped_reg <= (remain_reg == RESULT_W'(1)) ? lost_reg : '0;
        end
        else if (accept)
        begin
            p_event_reg   <= 1'b0;
            p_last_reg    <= 1'b1;
            p_dropped_reg <= drain_any ? lost_calc : '0;
        end
    end

    eehr_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_ring (
        .clk   (clk),
        .we    (is_log),
        .waddr (wp_reg),
        .wdata ({request.level, request.sample_time}),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    eehr_edge u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .log_en (is_log),
        .ref_en (is_ref),
        .level  (request.level),
        .cnt    (ecnt)
    );

    always_comb
    begin
        push_data.event_valid   = p_event_reg;
        push_data.event_level   = p_event_reg ? rdata[STAMP_W] : 1'b0;
        push_data.event_time_us = p_event_reg ? rdata[STAMP_W-1:0] : '0;
        push_data.last          = p_last_reg;
        push_data.dropped_total = p_dropped_reg;
        push_data.rise_count    = ecnt.rise;
        push_data.fall_count    = ecnt.fall;
        push_data.change_count  = ecnt.rise + ecnt.fall;
    end

    eehr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p_reg),
        .push_data (push_data),
        .count     (q_count),
        .result    (result)
    );

endmodule

>>> rtl/core/eehr_ram.sv
// Generic single-port-write, registered-read RAM.
module eehr_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/eehr_edge.sv
// Rise and fall counters against the last known pin level.
module eehr_edge
    import eehr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      log_en,
    input  logic      ref_en,
    input  logic      level,
    output edge_cnt_t cnt
);

    logic               prev_level_reg;
    logic               prev_known_reg;
    logic [CNT32_W-1:0] rise_reg;
    logic [CNT32_W-1:0] fall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            prev_known_reg <= 1'b0;
            rise_reg       <= '0;
            fall_reg       <= '0;
        end
        else if (log_en)
        begin
            if (prev_known_reg && (level != prev_level_reg))
            begin
                if (level)
                begin
                    rise_reg <= rise_reg + 1'b1;
                end
                else
                begin
                    fall_reg <= fall_reg + 1'b1;
                end
            end
            prev_known_reg <= 1'b1;
            prev_level_reg <= level;
        end
        else if (ref_en)
        begin
            prev_known_reg <= 1'b1;
            prev_level_reg <= level;
        end
    end

    assign cnt.rise = rise_reg;
    assign cnt.fall = fall_reg;

endmodule

>>> rtl/core/eehr_outq.sv
// Two-word result queue in front of the result channel.
module eehr_outq
    import eehr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output logic [1:0]  count,
    eehr_res_if.source  result
);

    result_t    ent_reg [2];
    logic       wr_idx_reg;
    logic       rd_idx_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;
    result_t    head;

    assign pop = result.valid && result.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_idx_reg <= ~wr_idx_reg;
            end
            if (pop)
            begin
                rd_idx_reg <= ~rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_idx_reg] <= push_data;
        end
    end

    assign head  = ent_reg[rd_idx_reg];
    assign count = cnt_reg;

    assign result.valid         = (cnt_reg != 2'd0);
    assign result.event_valid   = head.event_valid;
    assign result.event_level   = head.event_level;
    assign result.event_time_us = head.event_time_us;
    assign result.last          = head.last;
    assign result.dropped_total = head.dropped_total;
    assign result.rise_count    = head.rise_count;
    assign result.fall_count    = head.fall_count;
    assign result.change_count  = head.change_count;

endmodule
